// File: src/lmoe_pkg.sv
// ----------------------------------------------------------------------------
// lmoe_pkg: shared types and constants of the landmark One Euro smoother
// Register indexes, fixed-point constants and the queue entry type.
// ----------------------------------------------------------------------------
package lmoe_pkg;

    localparam int LANDMARKS = 33;
    localparam int CHANNELS  = 2 * LANDMARKS;
    localparam int CH_W      = $clog2(CHANNELS);

    localparam logic [1:0] REG_MIN_CUTOFF   = 2'd0;
    localparam logic [1:0] REG_SPEED_GAIN   = 2'd1;
    localparam logic [1:0] REG_DERIV_CUTOFF = 2'd2;
    localparam logic [1:0] REG_MIN_TIMESTEP = 2'd3;

    localparam logic [31:0] TWO_PI_Q28 = 32'd1686629713;
    localparam logic [16:0] ONE_Q16    = 17'd65536;

    // one beat handed from the front to the back
    typedef struct packed {
        logic [5:0]  index;
        logic        filt;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] vis;
        logic [16:0] dt;
    } item_t;

endpackage

// File: src/lmoe_ram.sv
// ----------------------------------------------------------------------------
// lmoe_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module lmoe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: src/lmoe_front.sv
// ----------------------------------------------------------------------------
// lmoe_front: input stage
// Accept a beat, work out the frame interval on index 0, tag the beat.
// ----------------------------------------------------------------------------
module lmoe_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [16:0]          min_timestep,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [5:0]           s_landmark_index,
    input  logic [31:0]          s_x_in,
    input  logic [31:0]          s_y_in,
    input  logic [31:0]          s_z_in,
    input  logic [31:0]          s_visibility_in,
    input  logic [47:0]          s_timestamp_ms,
    output logic                 q_valid,
    input  logic                 q_ready,
    output lmoe_pkg::item_t      q_item
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_TIME = 3'b010,
        F_SEND = 3'b100
    } fstate_t;

    fstate_t         state_reg, state_next;
    lmoe_pkg::item_t item_reg, item_next;
    logic [47:0]     prior_ts_reg, prior_ts_next;
    logic            seen_reg, seen_next;
    logic [16:0]     dt_reg, dt_next;
    logic [47:0]     delta_reg, delta_next;
    logic            fwd_reg, fwd_next;

    logic [16:0] floor_ts, measured, dt_calc;
    logic [27:0] prod;
    logic [63:0] recip;
    logic [47:0] quot;

    assign s_ready = (state_reg == F_IDLE);
    assign q_valid = (state_reg == F_SEND);
    assign q_item  = item_reg;

    // delta below 1000 here: divide by 1000 with an exact reciprocal multiply
    always_comb begin
        prod  = 28'({delta_reg[9:0], 16'd0});
        recip = 64'(prod) * 64'd68719477;
        quot  = 48'(recip >> 36);
        if (!fwd_reg) begin
            measured = 17'd0;
        end else if (delta_reg >= 48'd1000) begin
            measured = lmoe_pkg::ONE_Q16;
        end else begin
            measured = quot[16:0];
        end
        floor_ts = (min_timestep == 17'd0) ? 17'd1 : min_timestep;
        dt_calc  = (measured > floor_ts) ? measured : floor_ts;
        if (dt_calc > lmoe_pkg::ONE_Q16) begin
            dt_calc = lmoe_pkg::ONE_Q16;
        end
    end

    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        prior_ts_next = prior_ts_reg;
        seen_next     = seen_reg;
        dt_next       = dt_reg;
        delta_next    = delta_reg;
        fwd_next      = fwd_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (s_valid) begin
                    item_next.index = s_landmark_index;
                    item_next.filt  = ({26'd0, s_landmark_index} < lmoe_pkg::LANDMARKS);
                    item_next.x     = s_x_in;
                    item_next.y     = s_y_in;
                    item_next.z     = s_z_in;
                    item_next.vis   = s_visibility_in;
                    item_next.dt    = dt_reg;
                    if (s_landmark_index == 6'd0) begin
                        delta_next    = s_timestamp_ms - prior_ts_reg;
                        fwd_next      = seen_reg && (s_timestamp_ms > prior_ts_reg);
                        prior_ts_next = s_timestamp_ms;
                        seen_next     = 1'b1;
                        state_next    = F_TIME;
                    end else begin
                        state_next = F_SEND;
                    end
                end
            end
            F_TIME: begin
                dt_next      = dt_calc;
                item_next.dt = dt_calc;
                state_next   = F_SEND;
            end
            F_SEND: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= F_IDLE;
            prior_ts_reg <= '0;
            seen_reg     <= 1'b0;
            dt_reg       <= 17'd66;
        end else begin
            state_reg    <= state_next;
            prior_ts_reg <= prior_ts_next;
            seen_reg     <= seen_next;
            dt_reg       <= dt_next;
        end
        item_reg  <= item_next;
        delta_reg <= delta_next;
        fwd_reg   <= fwd_next;
    end
endmodule

// File: src/lmoe_div.sv
// ----------------------------------------------------------------------------
// lmoe_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, 64 by 48 bits.
// ----------------------------------------------------------------------------
module lmoe_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [47:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] q_reg, q_next;
    logic [48:0] r_reg, r_next;
    logic [47:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [48:0] trial;

    assign quotient = q_reg;
    assign done     = busy_reg && (cnt_reg == 7'd0);

    // shift in one dividend bit, subtract when it fits
    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[47:0], q_reg[63]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg && cnt_reg != 7'd0) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
        end else if (done) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end
endmodule

// File: src/lmoe_back.sv
// ----------------------------------------------------------------------------
// lmoe_back: filter sequencer
// Run the One Euro filter on x then y of a landmark beat, pass other beats as they are, then present the result.
// ----------------------------------------------------------------------------
module lmoe_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [31:0]      min_cutoff_hz,
    input  logic [31:0]      speed_gain,
    input  logic [31:0]      derivative_cutoff_hz,
    input  logic             q_valid,
    output logic             q_ready,
    input  lmoe_pkg::item_t  q_item,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [5:0]       m_landmark_out_index,
    output logic [31:0]      m_x_out,
    output logic [31:0]      m_y_out,
    output logic [31:0]      m_z_out,
    output logic [31:0]      m_visibility_out
);
    typedef enum logic [16:0] {
        B_IDLE  = 17'b00000000000000001,
        B_READ  = 17'b00000000000000010,
        B_LOAD  = 17'b00000000000000100,
        B_DDIV  = 17'b00000000000001000,
        B_AW1   = 17'b00000000000010000,
        B_AW2   = 17'b00000000000100000,
        B_ADIV  = 17'b00000000001000000,
        B_DLP1  = 17'b00000000010000000,
        B_DLP2  = 17'b00000000100000000,
        B_CUT1  = 17'b00000001000000000,
        B_CUT2  = 17'b00000010000000000,
        B_VW1   = 17'b00000100000000000,
        B_VW2   = 17'b00001000000000000,
        B_VDIV  = 17'b00010000000000000,
        B_VLP1  = 17'b00100000000000000,
        B_VLP2  = 17'b01000000000000000,
        B_OUT   = 17'b10000000000000000
    } bstate_t;

    localparam int CHW = lmoe_pkg::CH_W;

    bstate_t          state_reg, state_next;
    lmoe_pkg::item_t  item_reg, item_next;
    logic             ysel_reg, ysel_next;
    logic [31:0]      xres_reg, xres_next;
    logic [31:0]      yres_reg, yres_next;
    logic             mval_reg, mval_next;
    logic [lmoe_pkg::CHANNELS-1:0] started_reg, started_next;
    logic [31:0]      sv_reg, sv_next, ss_reg, ss_next, pr_reg, pr_next;
    logic [31:0]      v_reg, v_next;
    logic [31:0]      deriv_reg, deriv_next;
    logic             dneg_reg, dneg_next;
    logic [63:0]      acc_reg, acc_next;
    logic [31:0]      cut_reg, cut_next;
    logic [15:0]      alpha_reg, alpha_next;

    logic             ram_we;
    logic [CHW-1:0]   ram_addr;
    logic [95:0]      ram_wdata, ram_rdata;
    logic             div_start, div_done;
    logic [63:0]      div_dividend, div_quot;
    logic [47:0]      div_divisor;

    lmoe_ram #(.WIDTH(96), .DEPTH(lmoe_pkg::CHANNELS)) u_state (
        .aclk (aclk), .we (ram_we), .addr (ram_addr),
        .wdata (ram_wdata), .rdata (ram_rdata)
    );

    lmoe_div u_div (
        .aclk (aclk), .aresetn (aresetn), .start (div_start),
        .dividend (div_dividend), .divisor (div_divisor),
        .done (div_done), .quotient (div_quot)
    );

    assign q_ready              = (state_reg == B_IDLE) && !mval_reg;
    assign m_valid              = mval_reg;
    assign m_landmark_out_index = item_reg.index;
    assign m_x_out              = xres_reg;
    assign m_y_out              = yres_reg;
    assign m_z_out              = item_reg.z;
    assign m_visibility_out     = item_reg.vis;
    assign ram_addr             = CHW'({item_reg.index, ysel_reg});

    // datapath temporaries
    logic [32:0] diff_vp;
    logic [32:0] mag_d;
    logic signed [32:0] lp_diff;
    logic signed [49:0] lp_prod;
    logic signed [31:0] lp_res;
    logic [31:0] ds_mag;
    logic [32:0] cut_sum;

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        ysel_next    = ysel_reg;
        xres_next    = xres_reg;
        yres_next    = yres_reg;
        mval_next    = mval_reg;
        started_next = started_reg;
        sv_next      = sv_reg;
        ss_next      = ss_reg;
        pr_next      = pr_reg;
        v_next       = v_reg;
        deriv_next   = deriv_reg;
        dneg_next    = dneg_reg;
        acc_next     = acc_reg;
        cut_next     = cut_reg;
        alpha_next   = alpha_reg;
        ram_we       = 1'b0;
        ram_wdata    = {sv_reg, ss_reg, pr_reg};
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        lp_diff      = '0;
        lp_prod      = '0;
        lp_res       = '0;
        ds_mag       = ss_reg[31] ? (~ss_reg + 32'd1) : ss_reg;
        cut_sum      = '0;
        diff_vp      = 33'($signed(v_reg)) - 33'($signed(pr_reg));
        mag_d        = diff_vp[32] ? (~diff_vp + 33'd1) : diff_vp;

        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE: begin
                if (q_valid && !mval_reg) begin
                    item_next = q_item;
                    ysel_next = 1'b0;
                    v_next    = q_item.x;
                    if (q_item.filt) begin
                        state_next = B_READ;
                    end else begin
                        xres_next  = q_item.x;
                        yres_next  = q_item.y;
                        state_next = B_OUT;
                    end
                end
            end
            B_READ: state_next = B_LOAD;
            B_LOAD: begin
                sv_next = ram_rdata[95:64];
                ss_next = ram_rdata[63:32];
                pr_next = ram_rdata[31:0];
                if (!started_reg[ram_addr]) begin
                    started_next[ram_addr] = 1'b1;
                    sv_next    = v_reg;
                    ss_next    = '0;
                    pr_next    = v_reg;
                    state_next = B_VLP2;
                end else begin
                    state_next = B_DDIV;
                end
            end
            B_DDIV: begin
                // |v - prior| * 65536 / dt, sign applied after
                if (!div_done) begin
                    div_start    = (acc_reg != 64'hFFFF_FFFF_FFFF_FFFF);
                    div_dividend = {15'd0, mag_d, 16'd0};
                    div_divisor  = 48'(item_reg.dt);
                    dneg_next    = diff_vp[32];
                    acc_next     = 64'hFFFF_FFFF_FFFF_FFFF;
                end else begin
                    acc_next = '0;
                    if (dneg_reg) begin
                        deriv_next = (div_quot > 64'h8000_0000) ? 32'h8000_0000
                                   : 32'(~div_quot + 64'd1);
                    end else begin
                        deriv_next = (div_quot > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF
                                   : div_quot[31:0];
                    end
                    cut_next   = derivative_cutoff_hz;
                    state_next = B_AW1;
                end
            end
            B_AW1, B_VW1: begin
                acc_next   = (64'(cut_reg) * 64'(item_reg.dt)) >> 16;
                state_next = (state_reg == B_AW1) ? B_AW2 : B_VW2;
            end
            B_AW2, B_VW2: begin
                acc_next   = (64'(acc_reg[32:0]) * 64'(lmoe_pkg::TWO_PI_Q28)) >> 28;
                state_next = (state_reg == B_AW2) ? B_ADIV : B_VDIV;
            end
            B_ADIV, B_VDIV: begin
                if (!div_done) begin
                    div_start    = (cut_reg != 32'hFFFF_FFFF) || (acc_reg[63] == 1'b0);
                    div_start    = !acc_reg[63];
                    div_dividend = {acc_reg[47:0], 16'd0};
                    div_divisor  = acc_reg[47:0] + 48'd65536;
                    acc_next[63] = 1'b1;
                end else begin
                    alpha_next = div_quot[15:0];
                    acc_next   = '0;
                    state_next = (state_reg == B_ADIV) ? B_DLP1 : B_VLP1;
                end
            end
            B_DLP1, B_VLP1: begin
                if (state_reg == B_DLP1) begin
                    lp_diff = 33'($signed(deriv_reg)) - 33'($signed(ss_reg));
                end else begin
                    lp_diff = 33'($signed(v_reg)) - 33'($signed(sv_reg));
                end
                lp_prod    = $signed({1'b0, alpha_reg}) * lp_diff;
                acc_next   = 64'($signed(lp_prod));
                state_next = (state_reg == B_DLP1) ? B_DLP2 : B_VLP2;
            end
            B_DLP2: begin
                lp_res     = 32'($signed(acc_reg) >>> 16);
                ss_next    = ss_reg + lp_res;
                state_next = B_CUT1;
            end
            B_CUT1: begin
                acc_next   = (64'(speed_gain) * 64'(ds_mag)) >> 16;
                state_next = B_CUT2;
            end
            B_CUT2: begin
                cut_sum    = 33'(min_cutoff_hz) + 33'(acc_reg[31:0]);
                cut_next   = (cut_sum[32] || acc_reg[47:32] != 16'd0) ? 32'hFFFF_FFFF
                           : cut_sum[31:0];
                pr_next    = v_reg;
                state_next = B_VW1;
            end
            B_VLP2: begin
                // finish value low pass; first samples arrive here directly
                if (started_reg[ram_addr] && acc_reg != 64'd0 && sv_reg != v_reg) begin
                    lp_res  = 32'($signed(acc_reg) >>> 16);
                    sv_next = sv_reg + lp_res;
                end else if (acc_reg != 64'd0) begin
                    lp_res  = 32'($signed(acc_reg) >>> 16);
                    sv_next = sv_reg + lp_res;
                end
                acc_next = '0;
                ram_we   = 1'b1;
                ram_wdata = {sv_next, ss_reg, pr_reg};
                if (!ysel_reg) begin
                    xres_next  = sv_next;
                    ysel_next  = 1'b1;
                    v_next     = item_reg.y;
                    state_next = B_READ;
                end else begin
                    yres_next  = sv_next;
                    state_next = B_OUT;
                end
            end
            B_OUT: begin
                mval_next  = 1'b1;
                state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            mval_reg    <= 1'b0;
            started_reg <= '0;
            acc_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            mval_reg    <= mval_next;
            started_reg <= started_next;
            acc_reg     <= acc_next;
        end
        item_reg  <= item_next;
        ysel_reg  <= ysel_next;
        xres_reg  <= xres_next;
        yres_reg  <= yres_next;
        sv_reg    <= sv_next;
        ss_reg    <= ss_next;
        pr_reg    <= pr_next;
        v_reg     <= v_next;
        deriv_reg <= deriv_next;
        dneg_reg  <= dneg_next;
        cut_reg   <= cut_next;
        alpha_reg <= alpha_next;
    end
endmodule

// File: src/landmark_one_euro_smoother.sv
// ----------------------------------------------------------------------------
// landmark_one_euro_smoother: One Euro smoothing of x and y landmark streams
// Front stage takes beats and sets the frame interval; back stage filters.
// ----------------------------------------------------------------------------
// When the landmark is filtered, the back stage runs x and y each through
// three passes of one shared 64-step bit-serial divider (derivative and two
// smoothing factors), plus multiplies, low-pass updates and a channel state
// RAM read and write. The first sample of a channel is taken as is. Beats
// with an index at or above the landmark count pass unfiltered. A one-entry
// queue between the stages lets the next beat be taken while the back stage
// works and its result waits on the output register.
module landmark_one_euro_smoother (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [5:0]  s_landmark_index,
    input  logic [31:0] s_x_in,
    input  logic [31:0] s_y_in,
    input  logic [31:0] s_z_in,
    input  logic [31:0] s_visibility_in,
    input  logic [47:0] s_timestamp_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_landmark_out_index,
    output logic [31:0] m_x_out,
    output logic [31:0] m_y_out,
    output logic [31:0] m_z_out,
    output logic [31:0] m_visibility_out
);
    logic [31:0] min_cutoff_reg, speed_gain_reg, deriv_cutoff_reg;
    logic [16:0] min_step_reg;
    logic        q_valid, q_ready;
    lmoe_pkg::item_t q_item;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_cutoff_reg   <= 32'd65536;
            speed_gain_reg   <= 32'd0;
            deriv_cutoff_reg <= 32'd65536;
            min_step_reg     <= 17'd66;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lmoe_pkg::REG_MIN_CUTOFF:   min_cutoff_reg   <= cfg_data;
                lmoe_pkg::REG_SPEED_GAIN:   speed_gain_reg   <= cfg_data;
                lmoe_pkg::REG_DERIV_CUTOFF: deriv_cutoff_reg <= cfg_data;
                lmoe_pkg::REG_MIN_TIMESTEP: min_step_reg     <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    lmoe_front u_front (
        .aclk (aclk), .aresetn (aresetn), .min_timestep (min_step_reg),
        .s_valid (s_valid), .s_ready (s_ready),
        .s_landmark_index (s_landmark_index), .s_x_in (s_x_in), .s_y_in (s_y_in),
        .s_z_in (s_z_in), .s_visibility_in (s_visibility_in),
        .s_timestamp_ms (s_timestamp_ms),
        .q_valid (q_valid), .q_ready (q_ready), .q_item (q_item)
    );

    lmoe_back u_back (
        .aclk (aclk), .aresetn (aresetn),
        .min_cutoff_hz (min_cutoff_reg), .speed_gain (speed_gain_reg),
        .derivative_cutoff_hz (deriv_cutoff_reg),
        .q_valid (q_valid), .q_ready (q_ready), .q_item (q_item),
        .m_valid (m_valid), .m_ready (m_ready),
        .m_landmark_out_index (m_landmark_out_index),
        .m_x_out (m_x_out), .m_y_out (m_y_out), .m_z_out (m_z_out),
        .m_visibility_out (m_visibility_out)
    );
endmodule

// File: sim/lmoe_checker.sv
// ----------------------------------------------------------------------------
// lmoe_checker: result predictor and scoreboard for the landmark smoother
// Watches the register port and both channels, runs its own fixed-point One
// Euro model on every accepted input beat and compares each output beat in
// order against the oldest predicted result.
// ----------------------------------------------------------------------------
module lmoe_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [5:0]  s_landmark_index,
    input  logic [31:0] s_x_in,
    input  logic [31:0] s_y_in,
    input  logic [31:0] s_z_in,
    input  logic [31:0] s_visibility_in,
    input  logic [47:0] s_timestamp_ms,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [5:0]  m_landmark_out_index,
    input  logic [31:0] m_x_out,
    input  logic [31:0] m_y_out,
    input  logic [31:0] m_z_out,
    input  logic [31:0] m_visibility_out,
    output int          fail_count,
    output int          pending,
    output int          beats_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [5:0]  index;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] vis;
    } landmark_beat_t;

    landmark_beat_t smoothed_q[$];

    // model copy of registers and filter state
    longint unsigned min_cut_hz, gain, deriv_cut_hz, min_step;
    longint          filt_value [lmoe_pkg::CHANNELS];
    longint          filt_speed [lmoe_pkg::CHANNELS];
    longint          last_raw   [lmoe_pkg::CHANNELS];
    bit              ch_live    [lmoe_pkg::CHANNELS];
    longint unsigned last_ts;
    bit              ts_valid;
    longint          dt_q16;

    initial begin
        fail_count = 0;
        pending    = 0;
        beats_seen = 0;
    end

    function automatic longint smoothing_gain(longint unsigned cutoff, longint dt);
        longint unsigned w, g;
        w = (cutoff * longint'(dt)) >> 16;
        g = (w * longint'(lmoe_pkg::TWO_PI_Q28)) >> 28;
        return longint'((g << 16) / (g + 64'd65536));
    endfunction

    function automatic longint lowpass(longint prev, longint raw, longint a);
        return prev + ((a * (raw - prev)) >>> 16);
    endfunction

    function automatic longint euro_filter(int c, longint v, longint dt);
        longint          deriv, ds, mag;
        longint unsigned cutoff;
        if (!ch_live[c]) begin
            filt_speed[c] = 0;
            filt_value[c] = v;
            last_raw[c]   = v;
            ch_live[c]    = 1'b1;
            return v;
        end
        deriv = ((v - last_raw[c]) * 64'sd65536) / dt;
        if (deriv > 64'sd2147483647) deriv = 64'sd2147483647;
        if (deriv < -64'sd2147483648) deriv = -64'sd2147483648;
        ds = lowpass(filt_speed[c], deriv, smoothing_gain(deriv_cut_hz, dt));
        filt_speed[c] = ds;
        mag = (ds < 0) ? -ds : ds;
        cutoff = min_cut_hz + ((gain * longint'(mag)) >> 16);
        if (cutoff > 64'hFFFF_FFFF) cutoff = 64'hFFFF_FFFF;
        last_raw[c]   = v;
        filt_value[c] = lowpass(filt_value[c], v, smoothing_gain(cutoff, dt));
        return filt_value[c];
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        landmark_beat_t  exp_b, got_b;
        longint          xv, yv, meas, floor_dt;
        longint unsigned d;
        if (!aresetn) begin
            min_cut_hz   = 65536;
            gain         = 0;
            deriv_cut_hz = 65536;
            min_step     = 66;
            for (int i = 0; i < lmoe_pkg::CHANNELS; i++) begin
                filt_value[i] = 0;
                filt_speed[i] = 0;
                last_raw[i]   = 0;
                ch_live[i]    = 1'b0;
            end
            last_ts  = 0;
            ts_valid = 1'b0;
            dt_q16   = 66;
            smoothed_q.delete();
        end else begin
            // track register writes
            if (cfg_we) begin
                case (cfg_index)
                    lmoe_pkg::REG_MIN_CUTOFF:   min_cut_hz   = cfg_data;
                    lmoe_pkg::REG_SPEED_GAIN:   gain         = cfg_data;
                    lmoe_pkg::REG_DERIV_CUTOFF: deriv_cut_hz = cfg_data;
                    lmoe_pkg::REG_MIN_TIMESTEP: min_step     = cfg_data[16:0];
                    default: ;
                endcase
            end
            // predict on every input beat
            if (s_valid && s_ready) begin
                xv = longint'($signed(s_x_in));
                yv = longint'($signed(s_y_in));
                if (s_landmark_index == 6'd0) begin
                    meas = 0;
                    if (ts_valid && s_timestamp_ms > last_ts) begin
                        d = s_timestamp_ms - last_ts;
                        meas = (d >= 1000) ? 65536 : longint'((d * 65536) / 1000);
                    end
                    floor_dt = (min_step == 0) ? 1 : longint'(min_step);
                    dt_q16 = (meas > floor_dt) ? meas : floor_dt;
                    if (dt_q16 > 65536) dt_q16 = 65536;
                    last_ts  = s_timestamp_ms;
                    ts_valid = 1'b1;
                end
                if (s_landmark_index < lmoe_pkg::LANDMARKS) begin
                    xv = euro_filter(2 * s_landmark_index, xv, dt_q16);
                    yv = euro_filter(2 * s_landmark_index + 1, yv, dt_q16);
                end
                exp_b.index = s_landmark_index;
                exp_b.x     = xv[31:0];
                exp_b.y     = yv[31:0];
                exp_b.z     = s_z_in;
                exp_b.vis   = s_visibility_in;
                smoothed_q.push_back(exp_b);
            end
            // compare every output beat with the oldest prediction
            if (m_valid && m_ready) begin
                beats_seen++;
                got_b.index = m_landmark_out_index;
                got_b.x     = m_x_out;
                got_b.y     = m_y_out;
                got_b.z     = m_z_out;
                got_b.vis   = m_visibility_out;
                if (smoothed_q.size() == 0) begin
                    report("unexpected beat, index", got_b.index, 0);
                end else begin
                    exp_b = smoothed_q.pop_front();
                    if (got_b.index !== exp_b.index) report("index", got_b.index, exp_b.index);
                    if (got_b.x !== exp_b.x) report("x_out", got_b.x, exp_b.x);
                    if (got_b.y !== exp_b.y) report("y_out", got_b.y, exp_b.y);
                    if (got_b.z !== exp_b.z) report("z_out", got_b.z, exp_b.z);
                    if (got_b.vis !== exp_b.vis) report("visibility_out", got_b.vis, exp_b.vis);
                end
            end
        end
        pending = smoothed_q.size();
    end

endmodule

// File: sim/tb_landmark_one_euro_smoother.sv
// ----------------------------------------------------------------------------
// tb_landmark_one_euro_smoother: stimulus and verdict for the smoother
// Drives frames of landmark beats through several register settings with
// random gaps and output stalls; the checker beside the block scores results.
// ----------------------------------------------------------------------------
module tb_landmark_one_euro_smoother;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int PHASE_ITEMS = 150;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = lmoe_pkg::REG_MIN_CUTOFF;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [5:0]  s_landmark_index = '0;
    logic [31:0] s_x_in = '0;
    logic [31:0] s_y_in = '0;
    logic [31:0] s_z_in = '0;
    logic [31:0] s_visibility_in = '0;
    logic [47:0] s_timestamp_ms = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_landmark_out_index;
    logic [31:0] m_x_out, m_y_out, m_z_out, m_visibility_out;

    int          fail_count, pending, beats_seen;
    int          accepted = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;
    bit          long_hold = 1'b0;
    longint unsigned frame_ts = 0;
    logic [31:0] track_x [64];
    logic [31:0] track_y [64];

    landmark_one_euro_smoother i_dut (.*);

    lmoe_checker i_checker (.*);

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // count input beats and cycles; stop a hung run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (s_valid && s_ready) accepted <= accepted + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off, none when quiet
    initial begin
        forever begin
            @(posedge aclk);
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (3000) @(posedge aclk);
                long_hold = 1'b0;
                m_ready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(logic [5:0] idx, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z, logic [31:0] vis, logic [47:0] ts);
        int target;
        // optional sender gap, then hold valid until taken
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_landmark_index <= idx;
        s_x_in           <= x;
        s_y_in           <= y;
        s_z_in           <= z;
        s_visibility_in  <= vis;
        s_timestamp_ms   <= ts;
        target = accepted + 1;
        wait (accepted == target);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // drop valid at the edge that took the last beat, then wait for results
    task automatic drain;
        s_valid <= 1'b0;
        wait (pending == 0);
        repeat (300) @(posedge aclk);
    endtask

    // random landmark moving near its last position, sometimes jumping
    task automatic random_landmark(logic [5:0] idx, logic [47:0] ts);
        logic [31:0] x, y;
        if ($urandom_range(0, 9) == 0) begin
            x = $urandom;
            y = $urandom;
        end else begin
            x = track_x[idx] + $signed($urandom_range(0, 262144)) - 131072;
            y = track_y[idx] + $signed($urandom_range(0, 262144)) - 131072;
        end
        track_x[idx] = x;
        track_y[idx] = y;
        send_beat(idx, x, y, $urandom, $urandom, ts);
    endtask

    // mostly well-formed frames, with odd timestamps and stray indexes
    task automatic random_phase(int count);
        int   sent, lm, r;
        logic [47:0] ts;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 19);
            if (r == 0) frame_ts = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
            else if (r == 1) frame_ts = frame_ts - $urandom_range(0, 50);
            else if (r == 2) frame_ts = frame_ts + $urandom_range(900, 3000);
            else frame_ts = frame_ts + $urandom_range(1, 60);
            frame_ts &= 48'hFFFF_FFFF_FFFF;
            random_landmark(6'd0, frame_ts[47:0]);
            sent++;
            for (int k = 0; k < $urandom_range(2, 10) && sent < count; k++) begin
                lm = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 63)
                                                 : $urandom_range(1, 32);
                ts = 48'({$urandom, $urandom});
                random_landmark(lm[5:0], ts);
                sent++;
            end
        end
    endtask

    initial begin
        for (int i = 0; i < 64; i++) begin
            track_x[i] = '0;
            track_y[i] = '0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: before any frame start, extremes, odd timestamps, stray index
        send_beat(6'd5, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 48'd0);
        send_beat(6'd5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 48'd0);
        send_beat(6'd0, 32'h0001_0000, 32'hFFFF_0000, 32'h1, 32'h0, 48'd100);
        send_beat(6'd32, 32'h0, 32'h0, 32'h0, 32'h0, 48'hFFFF_FFFF_FFFF);
        send_beat(6'd63, 32'hDEAD_BEEF, 32'h1234_5678, 32'h5555_5555, 32'hAAAA_AAAA, 48'h0);
        send_beat(6'd33, 32'h1, 32'hFFFF_FFFF, 32'h2, 32'h3, 48'h0);
        send_beat(6'd0, 32'h0002_0000, 32'hFFFE_0000, 32'h0, 32'h0, 48'd100);
        send_beat(6'd0, 32'h0003_0000, 32'hFFFD_0000, 32'h0, 32'h0, 48'd50);
        send_beat(6'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 48'd5000);
        send_beat(6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 48'd5033);
        send_beat(6'd32, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 48'd0);
        send_beat(6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 48'hFFFF_FFFF_FFFF);
        send_beat(6'd0, 32'h0, 32'h0, 32'h0, 32'h0, 48'hFFFF_FFFF_FFFF);
        frame_ts = 48'd6000;
        random_phase(PHASE_ITEMS);
        drain();

        // extremes: floor of zero, top gain and derivative cutoff
        write_reg(lmoe_pkg::REG_MIN_CUTOFF, 32'd1);
        write_reg(lmoe_pkg::REG_SPEED_GAIN, 32'hFFFF_FFFF);
        write_reg(lmoe_pkg::REG_DERIV_CUTOFF, 32'hFFFF_FFFF);
        write_reg(lmoe_pkg::REG_MIN_TIMESTEP, 32'd0);
        // let the output fill while the sender keeps offering
        long_hold = 1'b1;
        random_phase(PHASE_ITEMS);
        drain();

        // opposite extremes: huge cutoff, one-second floor
        write_reg(lmoe_pkg::REG_MIN_CUTOFF, 32'hFFFF_FFFF);
        write_reg(lmoe_pkg::REG_SPEED_GAIN, 32'd0);
        write_reg(lmoe_pkg::REG_DERIV_CUTOFF, 32'd1);
        write_reg(lmoe_pkg::REG_MIN_TIMESTEP, 32'h1_FFFF);
        random_phase(40);
        drain();
        write_reg(lmoe_pkg::REG_MIN_TIMESTEP, 32'd65536);
        random_phase(40);
        drain();

        // typical tuning, then a quiet tail with no idling
        write_reg(lmoe_pkg::REG_MIN_CUTOFF, 32'h0000_8000);
        write_reg(lmoe_pkg::REG_SPEED_GAIN, 32'h0000_0A00);
        write_reg(lmoe_pkg::REG_DERIV_CUTOFF, 32'h0001_0000);
        write_reg(lmoe_pkg::REG_MIN_TIMESTEP, 32'd33);
        random_phase(PHASE_ITEMS);
        quiet = 1'b1;
        random_phase(80);
        drain();

        $display("Run covered %0d input beats and %0d result beats", accepted, beats_seen);
        $display("across five register settings with gaps, stalls and a long hold-off");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: landmark_one_euro_smoother.f
src/lmoe_pkg.sv
src/lmoe_ram.sv
src/lmoe_front.sv
src/lmoe_div.sv
src/lmoe_back.sv
src/landmark_one_euro_smoother.sv
sim/lmoe_checker.sv
sim/tb_landmark_one_euro_smoother.sv
